// ===== src/bwv_pkg.sv =====
// Shared constants for the variable-bits bit packer: field widths,
// operation codes and parameter defaults. No dependencies.

package bwv_pkg;

    localparam int DATA_W         = 64;
    localparam int WIDTH_W        = 7;
    localparam int OP_W           = 2;
    localparam int BYTE_W         = 8;
    localparam int S_TDATA_W      = 72;
    localparam int MAX_GROUPS_DEF = 64;

    localparam logic [OP_W-1:0] OP_PLAIN   = 2'd0;
    localparam logic [OP_W-1:0] OP_VARBITS = 2'd1;
    localparam logic [OP_W-1:0] OP_ALIGN   = 2'd2;

endpackage

// ===== src/bitstream_writer_varbits_top.sv =====
// MSB-first bit packer with plain, variable-bits and align operations.
// Depends on bwv_pkg and bwv_ram (group stack).
//
// Flow: one beat at a time; ready only while idle. A plain write places its field into
// the open byte through the merge unit, which places at most one byte's worth of bits
// per cycle when the output does not stall. A variable-bits write of G groups of n bits
// splits the groups one by one onto the stack, then per group does a stack read, a
// load, the merge steps and an end check. Reset (rst_n low, asynchronous) empties the
// open byte, the group count and the output stage; the group stack is not cleared.

module bitstream_writer_varbits_top #(
    parameter int MAX_GROUPS = bwv_pkg::MAX_GROUPS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input stream
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // [6:0] field_width, [70:7] value, [71] zero
    input  logic [bwv_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // [1:0] operation
    input  logic [bwv_pkg::OP_W-1:0]     s_axis_tuser,
    // output stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [7:0] out_byte
    output logic [bwv_pkg::BYTE_W-1:0]   m_axis_tdata,
    // last_of_run
    output logic                         m_axis_tlast
);

    localparam int DW = bwv_pkg::DATA_W;
    localparam int WW = bwv_pkg::WIDTH_W;
    localparam int BW = bwv_pkg::BYTE_W;
    localparam int AW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
    localparam int CW = $clog2(MAX_GROUPS + 1);
    localparam int SW = $clog2(DW);          // shift amount width
    localparam int TW = $clog2(BW + 1);      // bits per merge step, 0..8

    typedef enum logic [2:0] {
        S_IDLE,
        S_SPLIT,
        S_READ,
        S_LOAD,
        S_EMIT,
        S_FLUSH
    } state_t;

    // Input field unpacking
    logic [bwv_pkg::OP_W-1:0] in_op;
    logic [WW-1:0]            in_width;
    logic [DW-1:0]            in_value;
    logic                     in_fire;

    assign in_op    = s_axis_tuser;
    assign in_width = s_axis_tdata[WW-1:0];
    assign in_value = s_axis_tdata[WW+DW-1:WW];

    // Control and payload registers
    state_t                   state_reg, state_next;
    logic [bwv_pkg::OP_W-1:0] op_reg, op_next;
    logic [SW-1:0]            n_reg, n_next;          // group width, 1..63
    logic [DW-1:0]            rest_reg, rest_next;    // remainder during split
    logic [CW-1:0]            cnt_reg, cnt_next;      // groups on the stack
    logic                     cont_reg, cont_next;    // continuation bit of group in flight
    logic [DW-1:0]            shreg_reg, shreg_next;  // field bits, left aligned
    logic [WW-1:0]            left_reg, left_next;    // field bits still to place
    logic [BW-1:0]            partial_reg, partial_next;
    logic [2:0]               pos_reg, pos_next;
    logic [BW-1:0]            pend_reg, pend_next;    // completed byte held back
    logic                     pend_valid_reg, pend_valid_next;
    logic                     out_valid_reg, out_valid_next;
    logic [BW-1:0]            out_byte_reg, out_byte_next;
    logic                     out_last_reg, out_last_next;

    // Group stack port signals
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    logic [DW-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    logic [DW-1:0] ram_rd_data;

    // Shared units
    logic [DW-1:0] align_data;
    logic [WW-1:0] align_w;
    logic [WW-1:0] align_sh;
    logic [DW-1:0] aligned;
    logic [DW-1:0] shr_in;
    logic [SW-1:0] shr_n;
    logic [DW-1:0] shr_out;
    logic [DW-1:0] grp_mask;
    logic [DW-1:0] rest_dec;

    // Merge unit
    logic [TW-1:0] room;
    logic [TW-1:0] take;
    logic [TW-1:0] pos_sum;
    logic          byte_done;
    logic [BW-1:0] merged;
    logic          out_free;
    logic          stall;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tlast  = out_last_reg;

    // Left-align a field of align_w bits in the shift register
    assign align_sh = WW'(DW) - align_w;
    assign aligned  = align_data << align_sh[SW-1:0];

    // Right shift and mask shared by the first split and each later split
    assign shr_out  = shr_in >> shr_n;
    assign grp_mask = ~({DW{1'b1}} << shr_n);
    assign rest_dec = rest_reg - DW'(1);

    // Place up to one byte's worth of field bits into the open byte
    assign room      = TW'(BW) - TW'(pos_reg);
    assign take      = (left_reg < WW'(room)) ? left_reg[TW-1:0] : room;
    assign pos_sum   = TW'(pos_reg) + take;
    assign byte_done = pos_sum[TW-1];
    assign merged    = partial_reg | (shreg_reg[DW-1 -: BW] >> pos_reg);
    assign out_free  = !out_valid_reg || m_axis_tready;
    assign stall     = byte_done && pend_valid_reg && !out_free;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        n_next          = n_reg;
        rest_next       = rest_reg;
        cnt_next        = cnt_reg;
        cont_next       = cont_reg;
        shreg_next      = shreg_reg;
        left_next       = left_reg;
        partial_next    = partial_reg;
        pos_next        = pos_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_byte_next   = out_byte_reg;
        out_last_next   = out_last_reg;

        ram_wr_en   = 1'b0;
        ram_wr_addr = cnt_reg[AW-1:0];
        ram_wr_data = shr_in & grp_mask;
        ram_rd_en   = 1'b0;
        ram_rd_addr = AW'(cnt_reg - CW'(1));

        align_data = {ram_rd_data[DW-2:0], cont_reg};
        align_w    = WW'(n_reg) + WW'(1);
        shr_in     = rest_dec;
        shr_n      = n_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                align_data = in_value;
                align_w    = in_width;
                shr_in     = in_value;
                shr_n      = in_width[SW-1:0];
                if (in_fire)
                begin
                    op_next = in_op;
                    n_next  = in_width[SW-1:0];
                    unique case (in_op)
                        bwv_pkg::OP_PLAIN:
                        begin
                            if (in_width <= WW'(DW))
                            begin
                                shreg_next = aligned;
                                left_next  = in_width;
                                state_next = S_EMIT;
                            end
                            else
                            begin
                                state_next = S_FLUSH;
                            end
                        end
                        bwv_pkg::OP_VARBITS:
                        begin
                            if (in_width != '0 && in_width < WW'(DW))
                            begin
                                // first group is the low bits; hold the remainder
                                ram_wr_en   = 1'b1;
                                ram_wr_addr = '0;
                                rest_next   = shr_out;
                                cnt_next    = CW'(1);
                                state_next  = S_SPLIT;
                            end
                            else
                            begin
                                state_next = S_FLUSH;
                            end
                        end
                        bwv_pkg::OP_ALIGN:
                        begin
                            shreg_next = '0;
                            left_next  = (pos_reg == '0) ? '0 : WW'(room);
                            state_next = S_EMIT;
                        end
                        default:
                        begin
                            state_next = S_FLUSH;
                        end
                    endcase
                end
            end

            S_SPLIT:
            begin
                if (rest_reg != '0 && cnt_reg < CW'(MAX_GROUPS))
                begin
                    ram_wr_en = 1'b1;
                    rest_next = shr_out;
                    cnt_next  = cnt_reg + CW'(1);
                end
                else
                begin
                    state_next = S_READ;
                end
            end

            S_READ:
            begin
                // pop the most recently computed group
                ram_rd_en  = 1'b1;
                cnt_next   = cnt_reg - CW'(1);
                cont_next  = (cnt_reg > CW'(1));
                state_next = S_LOAD;
            end

            S_LOAD:
            begin
                shreg_next = aligned;
                left_next  = align_w;
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (left_reg == '0)
                begin
                    if (op_reg == bwv_pkg::OP_VARBITS && cnt_reg != '0)
                    begin
                        state_next = S_READ;
                    end
                    else
                    begin
                        state_next = S_FLUSH;
                    end
                end
                else if (!stall)
                begin
                    shreg_next = shreg_reg << take;
                    left_next  = left_reg - WW'(take);
                    if (byte_done)
                    begin
                        if (pend_valid_reg)
                        begin
                            // a later byte exists, so the held one is not the last
                            out_valid_next = 1'b1;
                            out_byte_next  = pend_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_next       = merged;
                        pend_valid_next = 1'b1;
                        partial_next    = '0;
                        pos_next        = '0;
                    end
                    else
                    begin
                        partial_next = merged;
                        pos_next     = pos_sum[2:0];
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_byte_next   = pend_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            op_reg         <= bwv_pkg::OP_PLAIN;
            n_reg          <= '0;
            rest_reg       <= '0;
            cnt_reg        <= '0;
            cont_reg       <= 1'b0;
            shreg_reg      <= '0;
            left_reg       <= '0;
            partial_reg    <= '0;
            pos_reg        <= '0;
            pend_reg       <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_byte_reg   <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            n_reg          <= n_next;
            rest_reg       <= rest_next;
            cnt_reg        <= cnt_next;
            cont_reg       <= cont_next;
            shreg_reg      <= shreg_next;
            left_reg       <= left_next;
            partial_reg    <= partial_next;
            pos_reg        <= pos_next;
            pend_reg       <= pend_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            out_byte_reg   <= out_byte_next;
            out_last_reg   <= out_last_next;
        end
    end

    bwv_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_GROUPS),
        .ADDR_W(AW)
    ) u_group_stack (
        .clk    (clk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(ram_wr_data),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    // The stack is empty whenever a new beat may enter
    a_stack_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (cnt_reg == '0))
        else $error("group stack not empty while idle");

    // Group count never passes the stack depth
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(MAX_GROUPS))
        else $error("group count beyond stack depth");

    // No held byte survives to idle
    a_pend_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("completed byte left behind");

    // A byte marked last comes only from the closing flush
    a_last_from_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_next && out_last_next && !(out_valid_reg && !m_axis_tready))
            |-> (state_reg == S_FLUSH))
        else $error("last byte issued outside flush");

    // An align leaves the open byte empty
    a_align_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && op_reg == bwv_pkg::OP_ALIGN && left_reg == '0)
            |-> (pos_reg == '0))
        else $error("align left bits in the open byte");

endmodule

// ===== src/bwv_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module bwv_ram #(
    parameter int WIDTH  = 64,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sim/bitstream_writer_varbits_top_tb.sv =====
// Self-checking testbench for bitstream_writer_varbits_top: predicts the packed byte
// stream of plain, variable-bits and align beats and checks every output beat.
// Depends on bwv_pkg and the RTL of the packer.

module bitstream_writer_varbits_top_tb;

    localparam int DATA_W         = bwv_pkg::DATA_W;
    localparam int WIDTH_W        = bwv_pkg::WIDTH_W;
    localparam int OP_W           = bwv_pkg::OP_W;
    localparam int BYTE_W         = bwv_pkg::BYTE_W;
    localparam int S_TDATA_W      = bwv_pkg::S_TDATA_W;
    localparam int MAX_GROUPS_DEF = bwv_pkg::MAX_GROUPS_DEF;

    // the fourth operation code has no meaning and must be ignored by the block
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
    localparam int MAX_IDLE     = 8;
    localparam int DRAIN_CYCLES = 300;   // wait after the final drain, watching for stray bytes

    typedef struct packed {
        logic [BYTE_W-1:0] octet;
        logic              tail;
    } stream_byte_t;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [S_TDATA_W-1:0]    s_axis_tdata;
    logic [OP_W-1:0]         s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [BYTE_W-1:0]       m_axis_tdata;
    logic                    m_axis_tlast;

    // bytes still owed by the block, oldest first
    stream_byte_t            byte_q[$];
    // model of the open byte
    logic [BYTE_W-1:0]       open_byte;
    int unsigned             open_bits;
    int unsigned             bytes_this_beat;
    bit                      no_idle;
    int unsigned             errors;

    bitstream_writer_varbits_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #10 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // Predictor: place bits MSB first, emit each byte as it completes
    // ------------------------------------------------------------------
    task automatic place_bit(input logic b);
        stream_byte_t done;
        open_byte[7 - open_bits] = b;
        open_bits++;
        if (open_bits == 8)
        begin
            done.octet = open_byte;
            done.tail  = 1'b0;
            byte_q     = {byte_q, done};
            bytes_this_beat++;
            open_byte = '0;
            open_bits = 0;
        end
    endtask

    task automatic place_field(input int unsigned n, input logic [DATA_W-1:0] v);
        for (int i = n; i > 0; i--)
            place_bit(v[i-1]);
    endtask

    task automatic place_varbits(input int unsigned n, input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0] mask;
        logic [DATA_W-1:0] rest;
        logic [DATA_W-1:0] groups [MAX_GROUPS_DEF];
        int unsigned       cnt;
        mask      = (64'd1 << n) - 64'd1;
        rest      = v >> n;
        groups[0] = v & mask;
        cnt       = 1;
        // each further group takes the remainder less one
        while (rest != 0 && cnt < MAX_GROUPS_DEF)
        begin
            rest        = rest - 64'd1;
            groups[cnt] = rest & mask;
            cnt++;
            rest        = rest >> n;
        end
        // last computed goes out first; continuation bit clear only on the final group
        for (int i = cnt; i > 0; i--)
        begin
            place_field(n, groups[i-1]);
            place_bit(i > 1);
        end
    endtask

    task automatic predict_beat(input logic [OP_W-1:0] op, input logic [WIDTH_W-1:0] width,
                                input logic [DATA_W-1:0] value);
        bytes_this_beat = 0;
        case (op)
            bwv_pkg::OP_PLAIN:
                if (width <= DATA_W)
                    place_field(32'(width), value);
            bwv_pkg::OP_VARBITS:
                if (width >= 1 && width < DATA_W)
                    place_varbits(32'(width), value);
            bwv_pkg::OP_ALIGN:
                while (open_bits != 0)
                    place_bit(1'b0);
            default: ;
        endcase
        if (bytes_this_beat > 0)
            byte_q[byte_q.size()-1].tail = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Stimulus side: one beat at a time, random gap before each
    // ------------------------------------------------------------------
    task automatic send_beat(input logic [OP_W-1:0] op, input logic [WIDTH_W-1:0] width,
                             input logic [DATA_W-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, value, width};
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_beat(op, width, value);
    endtask

    task automatic hold_off;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_random_beat;
        int unsigned       pick;
        logic [OP_W-1:0]   op;
        logic [WIDTH_W-1:0] width;
        logic [DATA_W-1:0] value;
        pick  = $urandom_range(0, 99);
        value = {$urandom, $urandom};
        // shorten the value often, so that codes of few groups dominate
        if ($urandom_range(0, 2) != 0)
            value = value >> $urandom_range(0, DATA_W);
        if (pick < 45)
        begin
            op    = bwv_pkg::OP_PLAIN;
            width = ($urandom_range(0, 19) == 0) ? WIDTH_W'($urandom_range(DATA_W + 1, 127))
                                                 : WIDTH_W'($urandom_range(0, DATA_W));
        end
        else if (pick < 82)
        begin
            op = bwv_pkg::OP_VARBITS;
            case ($urandom_range(0, 19))
                0:       width = '0;
                1:       width = WIDTH_W'(DATA_W);
                2:       width = WIDTH_W'($urandom_range(DATA_W + 1, 127));
                3, 4, 5: width = WIDTH_W'($urandom_range(17, DATA_W - 1));
                default: width = WIDTH_W'($urandom_range(1, 16));
            endcase
        end
        else if (pick < 96)
        begin
            op    = bwv_pkg::OP_ALIGN;
            width = WIDTH_W'($urandom_range(0, 127));
        end
        else
        begin
            op    = OP_RESERVED;
            width = WIDTH_W'($urandom_range(0, 127));
        end
        send_beat(op, width, value);
    endtask

    // ------------------------------------------------------------------
    // Output side: random stall before each byte, checked at the rising edge
    // ------------------------------------------------------------------
    initial
    begin : output_sink
        int stall;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
            repeat (stall)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    always @(posedge clk)
    begin : check_bytes
        stream_byte_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (byte_q.size() == 0)
                flag_mismatch($sformatf("unexpected byte %02h tlast %0b",
                                        m_axis_tdata, m_axis_tlast));
            else
            begin
                want = byte_q.pop_front();
                if (m_axis_tdata !== want.octet)
                    flag_mismatch($sformatf("byte %02h, expected %02h",
                                            m_axis_tdata, want.octet));
                if (m_axis_tlast !== want.tail)
                    flag_mismatch($sformatf("tlast %0b, expected %0b on byte %02h",
                                            m_axis_tlast, want.tail, want.octet));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_plain_fields;
        send_beat(bwv_pkg::OP_PLAIN, 7'd0,   64'hFFFF_FFFF_FFFF_FFFF);   // zero width: nothing
        send_beat(bwv_pkg::OP_PLAIN, 7'd1,   64'd1);
        send_beat(bwv_pkg::OP_PLAIN, 7'd64,  64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(bwv_pkg::OP_PLAIN, 7'd64,  64'd0);
        send_beat(bwv_pkg::OP_PLAIN, 7'd65,  64'hFFFF_FFFF_FFFF_FFFF);   // too wide: ignored
        send_beat(bwv_pkg::OP_PLAIN, 7'd127, 64'hA5A5_5A5A_0F0F_F0F0);   // too wide: ignored
        send_beat(bwv_pkg::OP_PLAIN, 7'd7,   64'h55);
        send_beat(bwv_pkg::OP_PLAIN, 7'd8,   64'hC3);
    endtask

    task automatic test_varbits_codes;
        send_beat(bwv_pkg::OP_VARBITS, 7'd0,  64'h1234);                 // zero group width
        send_beat(bwv_pkg::OP_VARBITS, 7'd64, 64'h1234);                 // full width: nothing
        send_beat(bwv_pkg::OP_VARBITS, 7'd96, 64'h1234);
        send_beat(bwv_pkg::OP_VARBITS, 7'd1,  64'd0);
        send_beat(bwv_pkg::OP_VARBITS, 7'd1,  64'hFFFF_FFFF_FFFF_FFFF);   // most groups
        send_beat(bwv_pkg::OP_VARBITS, 7'd63, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(bwv_pkg::OP_VARBITS, 7'd8,  64'd300);
        send_beat(bwv_pkg::OP_VARBITS, 7'd3,  64'h1B);
    endtask

    task automatic test_align_and_ignored;
        send_beat(bwv_pkg::OP_ALIGN, 7'd0,   64'd0);                  // pad the open byte
        send_beat(bwv_pkg::OP_ALIGN, 7'd0,   64'd0);                  // already aligned
        send_beat(bwv_pkg::OP_PLAIN, 7'd3,   64'h5);
        send_beat(OP_RESERVED,       7'd64,  64'hFFFF_FFFF_FFFF_FFFF);  // ignored
        send_beat(bwv_pkg::OP_ALIGN, 7'd127, 64'hFFFF_FFFF_FFFF_FFFF);
        send_beat(bwv_pkg::OP_PLAIN, 7'd12,  64'hABC);
        send_beat(bwv_pkg::OP_ALIGN, 7'd0,   64'd0);
    endtask

    task automatic test_random_mix(input int count);
        repeat (count)
            send_random_beat();
    endtask

    // hold the input back until every owed byte has come out, then resume
    task automatic test_pause_until_drained;
        repeat (20)
            send_random_beat();
        hold_off();
        wait (byte_q.size() == 0);
        repeat (20)
            send_random_beat();
    endtask

    task automatic test_back_to_back;
        no_idle = 1'b1;
        repeat (40)
            send_random_beat();
        no_idle = 1'b0;
    endtask

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = bwv_pkg::OP_PLAIN;
        open_byte     = '0;
        open_bits     = 0;
        no_idle       = 1'b0;
        errors        = 0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_plain_fields();
        test_varbits_codes();
        test_align_and_ignored();
        test_random_mix(60);
        test_pause_until_drained();
        test_back_to_back();
        test_random_mix(40);

        // drop valid, let every owed byte drain, then watch for strays
        hold_off();
        wait (byte_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout: %0d bytes still owed", byte_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
src/bwv_pkg.sv
src/bwv_ram.sv
src/bitstream_writer_varbits_top.sv
sim/bitstream_writer_varbits_top_tb.sv
